// ===== rtl/qpa_pkg.sv =====
// qpa_pkg: types, widths and helper functions for the quaternion product accumulator.
// Used by every module under rtl/; depends on nothing.
`timescale 1ns / 1ps

package qpa_pkg;

    localparam int COMP_BITS = 16;
    localparam int PROD_BITS = 2 * COMP_BITS;
    localparam int TERM_BITS = PROD_BITS + 2;
    localparam int ACC_BITS  = 40;

    typedef logic signed [COMP_BITS-1:0] comp_t;
    typedef logic signed [PROD_BITS-1:0] prod_t;
    typedef logic signed [TERM_BITS-1:0] term_t;
    typedef logic signed [ACC_BITS-1:0]  acc_t;

    localparam acc_t ACC_MAX = {1'b0, {(ACC_BITS - 1){1'b1}}};
    localparam acc_t ACC_MIN = {1'b1, {(ACC_BITS - 1){1'b0}}};

    typedef struct packed {
        comp_t in_r;
        comp_t in_i;
        comp_t in_j;
        comp_t in_k;
        comp_t kern_r;
        comp_t kern_i;
        comp_t kern_j;
        comp_t kern_k;
        logic  first_term;
        logic  last_term;
    } in_t;

    typedef struct packed {
        acc_t sum_r;
        acc_t sum_i;
        acc_t sum_j;
        acc_t sum_k;
    } out_t;

    // per-stage control carried alongside the data
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic conj;
    } tag_t;

    // partial products, named <input part><kernel part>
    typedef struct packed {
        prod_t rr;
        prod_t ii;
        prod_t jj;
        prod_t kk;
        prod_t ri;
        prod_t ir;
        prod_t jk;
        prod_t kj;
        prod_t rj;
        prod_t ik;
        prod_t jr;
        prod_t ki;
        prod_t rk;
        prod_t ij;
        prod_t ji;
        prod_t kr;
    } prod_set_t;

    typedef struct packed {
        term_t r;
        term_t i;
        term_t j;
        term_t k;
    } term_set_t;

    function automatic acc_t sat_add(input acc_t base, input term_t term);
        logic signed [ACC_BITS:0] sum;
        acc_t                     res;
        sum = (ACC_BITS + 1)'(base) + (ACC_BITS + 1)'(term);
        if (sum[ACC_BITS] == sum[ACC_BITS-1])
            res = sum[ACC_BITS-1:0];
        else if (sum[ACC_BITS])
            res = ACC_MIN;
        else
            res = ACC_MAX;
        return res;
    endfunction

endpackage

// ===== rtl/qpa_mult.sv =====
// qpa_mult: sixteen component products of one quaternion pair, registered.
// Depends on qpa_pkg.
`timescale 1ns / 1ps

module qpa_mult
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  qpa_pkg::tag_t      tag,
    input  qpa_pkg::in_t       item,
    output qpa_pkg::tag_t      prod_tag,
    output qpa_pkg::prod_set_t prod
);

    localparam int PB = qpa_pkg::PROD_BITS;

    qpa_pkg::tag_t      tag_reg;
    qpa_pkg::prod_set_t prod_reg;
    qpa_pkg::prod_set_t prod_next;

    always_comb
    begin
        prod_next.rr = PB'(item.in_r) * PB'(item.kern_r);
        prod_next.ii = PB'(item.in_i) * PB'(item.kern_i);
        prod_next.jj = PB'(item.in_j) * PB'(item.kern_j);
        prod_next.kk = PB'(item.in_k) * PB'(item.kern_k);
        prod_next.ri = PB'(item.in_r) * PB'(item.kern_i);
        prod_next.ir = PB'(item.in_i) * PB'(item.kern_r);
        prod_next.jk = PB'(item.in_j) * PB'(item.kern_k);
        prod_next.kj = PB'(item.in_k) * PB'(item.kern_j);
        prod_next.rj = PB'(item.in_r) * PB'(item.kern_j);
        prod_next.ik = PB'(item.in_i) * PB'(item.kern_k);
        prod_next.jr = PB'(item.in_j) * PB'(item.kern_r);
        prod_next.ki = PB'(item.in_k) * PB'(item.kern_i);
        prod_next.rk = PB'(item.in_r) * PB'(item.kern_k);
        prod_next.ij = PB'(item.in_i) * PB'(item.kern_j);
        prod_next.ji = PB'(item.in_j) * PB'(item.kern_i);
        prod_next.kr = PB'(item.in_k) * PB'(item.kern_r);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else if (en)
        begin
            tag_reg <= tag;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod_tag = tag_reg;
    assign prod     = prod_reg;

endmodule

// ===== rtl/qpa_combine.sv =====
// qpa_combine: signs and sums the partial products into four product terms, registered.
// Conjugate mode flips the sign of every product that holds a kernel imaginary part.
// Depends on qpa_pkg.
`timescale 1ns / 1ps

module qpa_combine
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  qpa_pkg::tag_t      prod_tag,
    input  qpa_pkg::prod_set_t prod,
    output qpa_pkg::tag_t      term_tag,
    output qpa_pkg::term_set_t terms
);

    localparam int TB = qpa_pkg::TERM_BITS;

    qpa_pkg::tag_t      tag_reg;
    qpa_pkg::term_set_t terms_reg;
    qpa_pkg::term_set_t terms_next;
    qpa_pkg::term_t     g_r;
    qpa_pkg::term_t     g_i;
    qpa_pkg::term_t     g_j;
    qpa_pkg::term_t     g_k;

    always_comb
    begin
        g_r = TB'(prod.ii) + TB'(prod.jj) + TB'(prod.kk);
        g_i = TB'(prod.ri) + TB'(prod.jk) - TB'(prod.kj);
        g_j = TB'(prod.rj) - TB'(prod.ik) + TB'(prod.ki);
        g_k = TB'(prod.rk) + TB'(prod.ij) - TB'(prod.ji);
        if (prod_tag.conj)
        begin
            terms_next.r = TB'(prod.rr) + g_r;
            terms_next.i = TB'(prod.ir) - g_i;
            terms_next.j = TB'(prod.jr) - g_j;
            terms_next.k = TB'(prod.kr) - g_k;
        end
        else
        begin
            terms_next.r = TB'(prod.rr) - g_r;
            terms_next.i = TB'(prod.ir) + g_i;
            terms_next.j = TB'(prod.jr) + g_j;
            terms_next.k = TB'(prod.kr) + g_k;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else if (en)
        begin
            tag_reg <= prod_tag;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            terms_reg <= terms_next;
        end
    end

    assign term_tag = tag_reg;
    assign terms    = terms_reg;

endmodule

// ===== rtl/qpa_accum.sv =====
// qpa_accum: four 40-bit saturating accumulators and the result register.
// Depends on qpa_pkg.
`timescale 1ns / 1ps

module qpa_accum
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  qpa_pkg::tag_t      term_tag,
    input  qpa_pkg::term_set_t terms,
    input  logic               sums_ready,
    output logic               sums_valid,
    output qpa_pkg::out_t      sums
);

    qpa_pkg::out_t acc_reg;
    qpa_pkg::out_t acc_next;
    qpa_pkg::out_t base;
    qpa_pkg::out_t sums_reg;
    logic          sums_valid_reg;

    always_comb
    begin
        base = term_tag.first ? '0 : acc_reg;
        acc_next.sum_r = qpa_pkg::sat_add(base.sum_r, terms.r);
        acc_next.sum_i = qpa_pkg::sat_add(base.sum_i, terms.i);
        acc_next.sum_j = qpa_pkg::sat_add(base.sum_j, terms.j);
        acc_next.sum_k = qpa_pkg::sat_add(base.sum_k, terms.k);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg        <= '0;
            sums_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            if (term_tag.valid)
            begin
                acc_reg <= acc_next;
            end
            sums_valid_reg <= term_tag.valid & term_tag.last;
        end
        else if (sums_ready)
        begin
            sums_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && term_tag.valid && term_tag.last)
        begin
            sums_reg <= acc_next;
        end
    end

    assign sums_valid = sums_valid_reg;
    assign sums       = sums_reg;

endmodule

// ===== rtl/quaternion_product_accumulator.sv =====
// quaternion_product_accumulator: top level, input register, mode register and pipeline control.
// Depends on qpa_pkg, qpa_mult, qpa_combine, qpa_accum.
//
//   channel    | handshake                   | payload
//   -----------+-----------------------------+------------------------------
//   cfg        | cfg_valid / cfg_ready       | cfg_data (conj_kernel_mode)
//   operands   | operands_valid / _ready     | qpa_pkg::in_t
//   sums       | sums_valid / sums_ready     | qpa_pkg::out_t
//
// One transfer per cycle in while the pipeline is not held.
// Four register stages: input, products, terms, accumulators/result.
// The whole pipeline holds while a result waits and sums_ready is low.
// Reset clears valid bits, accumulators and the mode; cfg is always ready.
// The mode travels with each operand transfer.
`timescale 1ns / 1ps

module quaternion_product_accumulator
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic          cfg_data,
    input  logic          operands_valid,
    output logic          operands_ready,
    input  qpa_pkg::in_t  operands,
    output logic          sums_valid,
    input  logic          sums_ready,
    output qpa_pkg::out_t sums
);

    logic               mode_reg;
    logic               en;
    qpa_pkg::tag_t      in_tag;
    qpa_pkg::tag_t      s1_tag_reg;
    qpa_pkg::in_t       s1_item_reg;
    qpa_pkg::tag_t      prod_tag;
    qpa_pkg::prod_set_t prod;
    qpa_pkg::tag_t      term_tag;
    qpa_pkg::term_set_t terms;

    assign en             = !sums_valid || sums_ready;
    assign operands_ready = en;
    assign cfg_ready      = 1'b1;

    always_comb
    begin
        in_tag.valid = operands_valid;
        in_tag.first = operands.first_term;
        in_tag.last  = operands.last_term;
        in_tag.conj  = mode_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b0;
            s1_tag_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                mode_reg <= cfg_data;
            end
            if (en)
            begin
                s1_tag_reg <= in_tag;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && operands_valid)
        begin
            s1_item_reg <= operands;
        end
    end

    qpa_mult u_mult
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .tag      (s1_tag_reg),
        .item     (s1_item_reg),
        .prod_tag (prod_tag),
        .prod     (prod)
    );

    qpa_combine u_combine
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .prod_tag (prod_tag),
        .prod     (prod),
        .term_tag (term_tag),
        .terms    (terms)
    );

    qpa_accum u_accum
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .term_tag   (term_tag),
        .terms      (terms),
        .sums_ready (sums_ready),
        .sums_valid (sums_valid),
        .sums       (sums)
    );

endmodule

// ===== tb/testbench.sv =====
// testbench: self-checking bench for quaternion_product_accumulator.
// Predicts each emitted sum from the operand transfers and checks the results in order.
// Depends on qpa_pkg and the RTL under rtl/.
`timescale 1ns / 1ps

module testbench;

    localparam int             STALL_LIMIT      = 2000;
    localparam int             DRAIN_CYCLES     = 8;
    localparam int             LONG_HOLD_CYCLES = 120;
    localparam int             REPORT_CAP       = 200;
    localparam logic           MODE_PLAIN       = 1'b0;
    localparam logic           MODE_CONJ        = 1'b1;
    localparam qpa_pkg::comp_t C_MAX            = 16'sh7fff;
    localparam qpa_pkg::comp_t C_MIN            = 16'sh8000;
    localparam qpa_pkg::comp_t C_ONE            = 16'sd4096;
    localparam longint         SUM_HI           = 64'sd549755813887;
    localparam longint         SUM_LO           = -SUM_HI - 1;

    logic          clk = 1'b0;
    logic          rst_n;
    logic          cfg_valid;
    logic          cfg_ready;
    logic          cfg_data;
    logic          operands_valid;
    logic          operands_ready;
    qpa_pkg::in_t  operands;
    logic          sums_valid;
    logic          sums_ready;
    qpa_pkg::out_t sums;

    qpa_pkg::out_t pending_sums[$];
    longint        acc_model[4] = '{default: 0};
    logic          conj_model = MODE_PLAIN;
    int            mismatch_count = 0;
    bit            send_idle = 1'b1;
    bit            recv_idle = 1'b1;
    bit            long_hold_req = 1'b0;

    quaternion_product_accumulator dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .operands_valid (operands_valid),
        .operands_ready (operands_ready),
        .operands       (operands),
        .sums_valid     (sums_valid),
        .sums_ready     (sums_ready),
        .sums           (sums)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic longint clamp_sum(input longint s);
        longint res;
        if (s > SUM_HI)
            res = SUM_HI;
        else if (s < SUM_LO)
            res = SUM_LO;
        else
            res = s;
        return res;
    endfunction

    task automatic accumulate_product(input qpa_pkg::in_t op);
        longint        a, b, c, d, p, q, r, s;
        longint        t[4];
        qpa_pkg::out_t res;
        a = longint'(op.in_r);
        b = longint'(op.in_i);
        c = longint'(op.in_j);
        d = longint'(op.in_k);
        p = longint'(op.kern_r);
        q = longint'(op.kern_i);
        r = longint'(op.kern_j);
        s = longint'(op.kern_k);
        if (conj_model == MODE_CONJ)
        begin
            q = -q;
            r = -r;
            s = -s;
        end
        t[0] = a * p - b * q - c * r - d * s;
        t[1] = a * q + b * p + c * s - d * r;
        t[2] = a * r - b * s + c * p + d * q;
        t[3] = a * s + b * r - c * q + d * p;
        for (int n = 0; n < 4; n++)
        begin
            if (op.first_term)
                acc_model[n] = 0;
            acc_model[n] = clamp_sum(acc_model[n] + t[n]);
        end
        if (op.last_term)
        begin
            res.sum_r = qpa_pkg::acc_t'(acc_model[0]);
            res.sum_i = qpa_pkg::acc_t'(acc_model[1]);
            res.sum_j = qpa_pkg::acc_t'(acc_model[2]);
            res.sum_k = qpa_pkg::acc_t'(acc_model[3]);
            pending_sums.push_back(res);
        end
    endtask

    // operand and mode transfers feed the predictor
    always @(posedge clk)
    begin
        if (rst_n && operands_valid && operands_ready)
            accumulate_product(operands);
        if (rst_n && cfg_valid && cfg_ready)
            conj_model = cfg_data;
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < REPORT_CAP)
            $display("%0t ns: mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input qpa_pkg::acc_t got,
                               input qpa_pkg::acc_t want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && sums_valid && sums_ready)
        begin
            if (pending_sums.size() == 0)
                report_mismatch("sums transfer with no result expected");
            else
            begin
                qpa_pkg::out_t want;
                want = pending_sums.pop_front();
                check_field("sum_r", sums.sum_r, want.sum_r);
                check_field("sum_i", sums.sum_i, want.sum_i);
                check_field("sum_j", sums.sum_j, want.sum_j);
                check_field("sum_k", sums.sum_k, want.sum_k);
            end
        end
    end

    // receiver: random gaps per result, long hold-off on request
    initial
    begin
        int gap;
        sums_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (long_hold_req)
            begin
                sums_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
                long_hold_req = 1'b0;
            end
            gap = recv_idle ? $urandom_range(0, 10) : 0;
            if (gap > 0)
            begin
                sums_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            sums_ready <= 1'b1;
            @(posedge clk);
            while (!(sums_valid && sums_ready) && !long_hold_req)
                @(posedge clk);
            @(negedge clk);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((operands_valid && operands_ready) || (sums_valid && sums_ready)
                || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("== FAIL ==");
        $finish;
    end

    function automatic qpa_pkg::in_t make_op(input qpa_pkg::comp_t ir,
                                             input qpa_pkg::comp_t ii,
                                             input qpa_pkg::comp_t ij,
                                             input qpa_pkg::comp_t ik,
                                             input qpa_pkg::comp_t kr,
                                             input qpa_pkg::comp_t ki,
                                             input qpa_pkg::comp_t kj,
                                             input qpa_pkg::comp_t kk,
                                             input logic f, input logic l);
        qpa_pkg::in_t op;
        op.in_r       = ir;
        op.in_i       = ii;
        op.in_j       = ij;
        op.in_k       = ik;
        op.kern_r     = kr;
        op.kern_i     = ki;
        op.kern_j     = kj;
        op.kern_k     = kk;
        op.first_term = f;
        op.last_term  = l;
        return op;
    endfunction

    function automatic qpa_pkg::comp_t rand_comp();
        qpa_pkg::comp_t v;
        case ($urandom_range(0, 9))
            0:       v = C_MIN;
            1:       v = C_MAX;
            2:       v = '0;
            3, 4:    v = qpa_pkg::comp_t'(int'($urandom_range(0, 8192)) - 4096);
            default: v = qpa_pkg::comp_t'($urandom());
        endcase
        return v;
    endfunction

    function automatic qpa_pkg::in_t rand_op(input logic f, input logic l);
        return make_op(rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                       rand_comp(), rand_comp(), rand_comp(), rand_comp(), f, l);
    endfunction

    // entered and left at a falling edge
    task automatic send_op(input qpa_pkg::in_t op);
        int gap;
        gap = send_idle ? $urandom_range(0, 10) : 0;
        if (gap > 0)
        begin
            operands_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        operands       <= op;
        operands_valid <= 1'b1;
        @(posedge clk);
        while (!(operands_valid && operands_ready))
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic settle();
        operands_valid <= 1'b0;
        while (pending_sums.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_mode(input logic mode);
        cfg_data  <= mode;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!(cfg_valid && cfg_ready))
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic test_directed(input logic mode);
        settle();
        write_mode(mode);
        send_idle = 1'b1;
        recv_idle = 1'b1;
        send_op(make_op('0, '0, '0, '0, '0, '0, '0, '0, 1'b1, 1'b1));
        send_op(make_op(C_ONE, '0, '0, '0, rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                        1'b1, 1'b1));
        send_op(make_op(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, 1'b1, 1'b1));
        send_op(make_op(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, 1'b1, 1'b1));
        send_op(make_op(C_MIN, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MAX, 1'b1, 1'b1));
        send_op(make_op('0, C_ONE, '0, '0, '0, '0, C_ONE, '0, 1'b1, 1'b1));
        send_op(make_op('0, '0, '0, C_ONE, '0, C_ONE, '0, '0, 1'b1, 1'b1));
        // a group, then more terms on top of the emitted sums
        send_op(rand_op(1'b1, 1'b0));
        send_op(rand_op(1'b0, 1'b0));
        send_op(rand_op(1'b0, 1'b1));
        send_op(rand_op(1'b0, 1'b1));
        send_op(rand_op(1'b0, 1'b0));
        send_op(rand_op(1'b1, 1'b1));
    endtask

    task automatic test_saturation();
        settle();
        write_mode(MODE_PLAIN);
        for (int n = 0; n < 140; n++)
            send_op(make_op(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX,
                            n == 0, (n % 20) == 19));
        for (int n = 0; n < 8; n++)
            send_op(make_op(C_MIN, C_MIN, C_MIN, C_MIN, C_MAX, C_MIN, C_MIN, C_MIN,
                            1'b0, n == 7));
        settle();
        write_mode(MODE_CONJ);
        for (int n = 0; n < 140; n++)
            send_op(make_op(C_MIN, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MAX,
                            n == 0, (n % 20) == 19));
        for (int n = 0; n < 8; n++)
            send_op(make_op(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN,
                            1'b0, n == 7));
    endtask

    task automatic test_backpressure();
        settle();
        send_idle = 1'b0;
        recv_idle = 1'b0;
        long_hold_req = 1'b1;
        for (int n = 0; n < 40; n++)
            send_op(rand_op(1'b1, 1'b1));
        send_idle = 1'b1;
        recv_idle = 1'b1;
    endtask

    task automatic test_random_sums();
        int sent;
        int len;
        for (int phase = 0; phase < 8; phase++)
        begin
            settle();
            write_mode(1'($urandom_range(0, 1)));
            send_idle = ($urandom_range(0, 3) != 0);
            recv_idle = ($urandom_range(0, 3) != 0);
            sent = 0;
            while (sent < 60)
            begin
                if ($urandom_range(0, 99) < 85)
                begin
                    len = $urandom_range(1, 8);
                    for (int n = 0; n < len; n++)
                        send_op(rand_op(n == 0, n == len - 1));
                    sent += len;
                end
                else
                begin
                    send_op(rand_op(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = 1'b0;
        operands_valid = 1'b0;
        operands       = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed(MODE_PLAIN);
        test_directed(MODE_CONJ);
        test_saturation();
        test_backpressure();
        test_random_sums();

        operands_valid <= 1'b0;
        while (pending_sums.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_sums.size() != 0)
            report_mismatch("results still expected at end of run");
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
